// ===== hdl/ipru_pkg.sv =====
// ----------------------------------------------------------------------------
// ipru_pkg
// shared types and constants of the integer pixel replicate upscaler
// ----------------------------------------------------------------------------
package ipru_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_SCALE = 64;

  localparam int PIX_W       = 24;
  localparam int CHAN_W      = 8;
  localparam int SRC_WIDTH_W = 13;
  localparam int SCALE_W     = 7;
  localparam int CNT_W       = 7;   // holds a copy count up to 64
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH = 1'b0,
    REG_SCALE     = 1'b1
  } cfg_reg_t;

  // one accepted item on its way from the accept stage to the replicator
  typedef struct packed {
    logic             replay;
    logic             err;
    pix_t             pix;
    logic             at_end;
    logic [CNT_W-1:0] copies;
    logic [1:0]       pad;
  } item_t;

endpackage

// ===== hdl/ipru_if.sv =====
// ----------------------------------------------------------------------------
// ipru_if
// valid/ready channels for source items and output pixels
// ----------------------------------------------------------------------------
interface ipru_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, red, green, blue, input ready);
  modport sink   (input valid, func, red, green, blue, output ready);
endinterface

interface ipru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last_copy;
  logic       row_end;
  logic [1:0] pad_bytes;
  logic       error;

  modport source (output valid, out_red, out_green, out_blue, last_copy, row_end,
                  pad_bytes, error, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, last_copy, row_end,
                  pad_bytes, error, output ready);
endinterface

// ===== hdl/ipru_line_store.sv =====
// ----------------------------------------------------------------------------
// ipru_line_store
// single-port line memory, registered read
// ----------------------------------------------------------------------------
module ipru_line_store #(
  parameter int DEPTH = ipru_pkg::DEF_MAX_WIDTH,
  parameter int AW    = 12
) (
  input  logic           clk,
  input  logic           we,
  input  logic           re,
  input  logic [AW-1:0]  addr,
  input  ipru_pkg::pix_t wdata,
  output ipru_pkg::pix_t rdata_r
);

  ipru_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

// ===== hdl/ipru_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipru_ctrl
// config registers, kind check, row position and replay pass counters
// ----------------------------------------------------------------------------
module ipru_ctrl #(
  parameter int MAX_WIDTH = ipru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = ipru_pkg::DEF_MAX_SCALE,
  parameter int AW        = 12,
  parameter int RW        = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ipru_in_if.sink                         in_if,
  input  logic                            cfg_we,
  input  logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s1_take,
  output logic                            s1_valid,
  output ipru_pkg::item_t                 s1_item,
  output logic                            mem_we,
  output logic                            mem_re,
  output logic [AW-1:0]                   mem_addr,
  output ipru_pkg::pix_t                  mem_wdata
);

  localparam int WW = AW + 1;
  localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
  localparam logic [ipru_pkg::SCALE_W-1:0] MAX_S = ipru_pkg::SCALE_W'(MAX_SCALE);

  logic [ipru_pkg::SRC_WIDTH_W-1:0] src_width_r;
  logic [ipru_pkg::SCALE_W-1:0]     scale_r;
  logic [AW-1:0]                    column_r, column_nxt;
  logic [RW-1:0]                    replays_r, replays_nxt;
  logic                             s1_valid_r;
  ipru_pkg::item_t                  s1_item_r, item_nxt;

  logic [16:0]                  src17;
  logic [WW-1:0]                w_eff;
  logic [ipru_pkg::SCALE_W-1:0] s_eff;
  logic [WW-1:0]                col_inc;
  logic [3:0]                   pad_prod;
  logic                         in_ready;
  logic                         accept;
  logic                         want_replay;
  logic                         kind_err;
  logic                         at_end;
  logic                         good;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r <= ipru_pkg::SRC_WIDTH_W'(1);
      scale_r     <= ipru_pkg::SCALE_W'(1);
    end else if (cfg_we) begin
      case (ipru_pkg::cfg_reg_t'(cfg_index))
        ipru_pkg::REG_SRC_WIDTH: src_width_r <= cfg_data;
        ipru_pkg::REG_SCALE:     scale_r     <= cfg_data[ipru_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    src17 = {4'b0, src_width_r};
    if (src17 == 17'd0) begin
      w_eff = WW'(1);
    end else if (src17 > MAX_W17) begin
      w_eff = WW'(MAX_W17);
    end else begin
      w_eff = WW'(src17);
    end

    if (scale_r == '0) begin
      s_eff = ipru_pkg::SCALE_W'(1);
    end else if (scale_r > MAX_S) begin
      s_eff = MAX_S;
    end else begin
      s_eff = scale_r;
    end

    // pad is (w*s) mod 4, only the low bits matter
    pad_prod = {2'b0, w_eff[1:0]} * {2'b0, s_eff[1:0]};

    in_ready    = !s1_valid_r || s1_take;
    accept      = in_if.valid && in_ready;
    want_replay = (replays_r != '0);
    kind_err    = (in_if.func != want_replay);
    good        = accept && !kind_err;

    col_inc = {1'b0, column_r} + WW'(1);
    at_end  = (col_inc >= w_eff);

    column_nxt  = column_r;
    replays_nxt = replays_r;
    if (good) begin
      if (at_end) begin
        column_nxt = '0;
        if (!in_if.func) begin
          replays_nxt = RW'(s_eff - ipru_pkg::SCALE_W'(1));
        end else begin
          replays_nxt = replays_r - RW'(1);
        end
      end else begin
        column_nxt = col_inc[AW-1:0];
      end
    end

    item_nxt.replay = in_if.func;
    item_nxt.err    = kind_err;
    item_nxt.pix    = {in_if.red, in_if.green, in_if.blue};
    item_nxt.at_end = at_end && !kind_err;
    item_nxt.copies = kind_err ? ipru_pkg::CNT_W'(1) : ipru_pkg::CNT_W'(s_eff);
    item_nxt.pad    = (at_end && !kind_err) ? pad_prod[1:0] : 2'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      replays_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      column_r  <= column_nxt;
      replays_r <= replays_nxt;
      if (in_ready) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item_nxt;
    end
  end

  assign in_if.ready = in_ready;
  assign s1_valid    = s1_valid_r;
  assign s1_item     = s1_item_r;
  assign mem_we      = good && !in_if.func;
  assign mem_re      = good && in_if.func;
  assign mem_addr    = column_r;
  assign mem_wdata   = item_nxt.pix;

endmodule

// ===== hdl/ipru_emit.sv =====
// ----------------------------------------------------------------------------
// ipru_emit
// output register that repeats each pixel for its copy count
// ----------------------------------------------------------------------------
module ipru_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  ipru_pkg::item_t s1_item,
  input  ipru_pkg::pix_t  rdata,
  output logic            s1_take,
  ipru_out_if.source      out_if
);

  logic                       busy_r;
  logic [ipru_pkg::CNT_W-1:0] cnt_r;
  ipru_pkg::pix_t             pix_r;
  logic                       err_r;
  logic                       end_r;
  logic [1:0]                 pad_r;

  logic           last;
  logic           fire;
  logic           load;
  ipru_pkg::pix_t pix_sel;

  always_comb begin
    last = (cnt_r == ipru_pkg::CNT_W'(1));
    fire = busy_r && out_if.ready;
    load = s1_valid && (!busy_r || (fire && last));
    if (s1_item.err) begin
      pix_sel = '0;
    end else if (s1_item.replay) begin
      pix_sel = rdata;
    end else begin
      pix_sel = s1_item.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= s1_item.copies;
    end else if (fire) begin
      busy_r <= !last;
      cnt_r  <= cnt_r - ipru_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix_sel;
      err_r <= s1_item.err;
      end_r <= s1_item.at_end;
      pad_r <= s1_item.pad;
    end
  end

  assign s1_take          = load;
  assign out_if.valid     = busy_r;
  assign out_if.out_red   = pix_r[23:16];
  assign out_if.out_green = pix_r[15:8];
  assign out_if.out_blue  = pix_r[7:0];
  assign out_if.last_copy = last;
  assign out_if.row_end   = last && end_r;
  assign out_if.pad_bytes = last ? pad_r : 2'b0;
  assign out_if.error     = err_r;

endmodule

// ===== hdl/integer_pixel_replicate_upscaler.sv =====
// path: an item waits in the accept stage register, then loads into the output register
// throughput: one output pixel per cycle while out ready is high; an item gives scale
//   copies (an error item one), and the next item loads as its last copy leaves
// the rate is set by the single output register that repeats each pixel
// reset: synchronous active-low rst_n clears row position, replay count and
//   valids, and sets src_width and scale to 1; the line store is not cleared
// ----------------------------------------------------------------------------
// integer_pixel_replicate_upscaler
// nearest-neighbor integer upscaler: pixel replication along a row, row
// replication by replaying a line store
// ----------------------------------------------------------------------------
module integer_pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = ipru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = ipru_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ipru_in_if.sink                         in_if,
  ipru_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data
);

  // line store address bits and replay pass counter bits
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic            s1_valid;
  logic            s1_take;
  ipru_pkg::item_t s1_item;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;
  ipru_pkg::pix_t  mem_wdata;
  ipru_pkg::pix_t  mem_rdata;

  // accept stage: kind check, store write for new pixels, store read for
  // replays, column and replay pass bookkeeping; holds one item for the
  // replicator so a new transfer can come in while output is stalled
  ipru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .AW        (AW),
    .RW        (RW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_take   (s1_take),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  // one entry per source column; a replay read lands the cycle after its
  // transfer and stays put while the held item waits for the replicator.
  // a write and a later read of the same column fall on different transfers,
  // so no forwarding is needed
  ipru_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata)
  );

  // output register repeating each pixel scale times (an error item once); last copy flags
  // row end and padding
  ipru_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rdata    (mem_rdata),
    .s1_take  (s1_take),
    .out_if   (out_if)
  );

endmodule

// ===== hdl/ipru_chk.sv =====
// ----------------------------------------------------------------------------
// ipru_chk
// port-level checks on the output channel of the upscaler
// ----------------------------------------------------------------------------
module ipru_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       last_copy,
  input logic       row_end,
  input logic [1:0] pad_bytes,
  input logic       error
);

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // a row ends only on the last copy of an item
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && row_end |-> last_copy)
    else $error("row end without last copy");

  // padding is given only at a row end
  a_pad_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pad_bytes != 2'b0) |-> row_end)
    else $error("pad bytes outside a row end");

  // an error result is a single zero pixel
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error |-> last_copy && !row_end && (out_red == 8'd0) &&
                           (out_green == 8'd0) && (out_blue == 8'd0))
    else $error("malformed error result");

endmodule

bind integer_pixel_replicate_upscaler ipru_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_red   (out_if.out_red),
  .out_green (out_if.out_green),
  .out_blue  (out_if.out_blue),
  .last_copy (out_if.last_copy),
  .row_end   (out_if.row_end),
  .pad_bytes (out_if.pad_bytes),
  .error     (out_if.error)
);
